### design/http_chunked_body_decoder_assert.svh
// Assertion macros used by the checker of the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define HCBD_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hcbd check failed");

// Next-cycle implication, switched off while reset is asserted.
`define HCBD_ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hcbd check failed");

`endif

### design/hcbd_pkg.sv
package hcbd_pkg;

	localparam int LINE_BUFFER_BYTES_DEF = 256;
	localparam int SIZE_BITS_DEF         = 32;
	localparam logic [7:0] MAX_LINE_LEN_RST = 8'd255;

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_X_LC  = 8'h78;
	localparam logic [7:0] CHAR_X_UC  = 8'h58;

	// Register index of the only configuration register.
	localparam logic REG_MAX_LINE_LEN = 1'b0;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_TERM,
		PH_TRAILER,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_ZERO,
		PFX_DONE
	} prefix_t;

	typedef enum logic [1:0] {
		KIND_FRAME,
		KIND_PAYLOAD,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_MALFORMED,
		ERR_OVERFLOW,
		ERR_LONG
	} err_t;

	typedef struct packed {
		logic over;
		logic bad;
		logic ended;
		logic digits;
	} flags_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] pay;
		err_t       err;
	} result_t;

endpackage

### design/http_chunked_body_decoder.sv
// Chunked HTTP body decoder.
// Input channel (in_valid/in_ready): one raw body byte per word in data_byte; new_body
// high restarts decoding at a chunk-size line before that byte.
// Output channel (out_valid/out_ready): exactly one result word per input word, giving
// kind (framing, payload, body complete, error), payload_byte and error_code.
// Configuration: an APB-style port holding max_line_len at byte address 0; pready is
// tied high and a write lands on the access cycle.
// A result goes to the output register, or to the skid register on a stall. Throughput
// is one word per cycle while in_ready is high; each byte reads and writes parser state.
// At reset the parser sits at the start of a size line, max_line_len returns to 255 and
// both the output register and the skid register are empty.
// When the receiver stalls, one further word is absorbed by the skid register; only
// once that is full does in_ready fall, and it rises again as soon as the output drains.
module http_chunked_body_decoder #(
	parameter int LINE_BUFFER_BYTES = hcbd_pkg::LINE_BUFFER_BYTES_DEF,
	parameter int SIZE_BITS         = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        new_body,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [1:0]  error_code
);

	// The longest line the buffer could ever hold; the limit in force is the smaller of
	// this and the programmed register.
	localparam logic [7:0] LINE_CAP = 8'(LINE_BUFFER_BYTES - 1);

	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'b0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

	// Configuration register.
	logic [7:0] max_line_len_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == hcbd_pkg::REG_MAX_LINE_LEN);
	assign prdata = (paddr[2] == hcbd_pkg::REG_MAX_LINE_LEN) ? {24'b0, max_line_len_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_len_q <= hcbd_pkg::MAX_LINE_LEN_RST;
		end else if (cfg_wr) begin
			max_line_len_q <= pwdata[7:0];
		end
	end

	// Parser state.
	hcbd_pkg::phase_t       phase_q, phase_d, phase_e;
	logic [SIZE_BITS-1:0]   rem_q, rem_d, rem_e, rem_dec;
	logic [SIZE_BITS-1:0]   acc_q, acc_d, acc_e, acc_p;
	logic [7:0]             line_q, line_d, line_e;
	hcbd_pkg::flags_t       flags_q, flags_d, flags_e, flags_p;
	hcbd_pkg::prefix_t      prefix_q, prefix_d, prefix_e, prefix_p;
	logic                   term_q, term_d, term_e;
	logic                   crf_q, crf_d, crf_e;

	logic                   accept;
	logic [7:0]             limit;
	logic                   line_full;
	logic                   is_lf;
	logic                   is_blank;
	logic [4:0]             hex;
	logic                   take;
	hcbd_pkg::result_t      res;

	assign accept = in_valid && in_ready;

	// A restart request applies before the byte that carries it.
	always_comb begin
		if (new_body) begin
			phase_e  = hcbd_pkg::PH_SIZE;
			rem_e    = '0;
			acc_e    = '0;
			line_e   = '0;
			flags_e  = '0;
			prefix_e = hcbd_pkg::PFX_NONE;
			term_e   = 1'b0;
			crf_e    = 1'b0;
		end else begin
			phase_e  = phase_q;
			rem_e    = rem_q;
			acc_e    = acc_q;
			line_e   = line_q;
			flags_e  = flags_q;
			prefix_e = prefix_q;
			term_e   = term_q;
			crf_e    = crf_q;
		end
	end

	assign limit     = (max_line_len_q > LINE_CAP) ? LINE_CAP : max_line_len_q;
	assign line_full = line_e >= limit;
	assign is_lf     = data_byte == hcbd_pkg::CHAR_LF;
	assign is_blank  = data_byte == hcbd_pkg::CHAR_SPACE || data_byte == hcbd_pkg::CHAR_TAB
		|| data_byte == hcbd_pkg::CHAR_CR || data_byte == hcbd_pkg::CHAR_VT
		|| data_byte == hcbd_pkg::CHAR_FF;
	assign hex       = hex_decode(data_byte);
	assign rem_dec   = (rem_e != '0) ? rem_e - 1'b1 : rem_e;

	// Size line parsing for one byte: blanks before the first digit, an optional x
	// after a lone leading zero, and a stop at the first byte that is not hex.
	always_comb begin
		flags_p  = flags_e;
		acc_p    = acc_e;
		prefix_p = prefix_e;
		take     = 1'b0;
		if (!flags_e.ended) begin
			if (!flags_e.digits) begin
				if (is_blank) begin
					take = 1'b0;
				end else if (hex[4]) begin
					take     = 1'b1;
					prefix_p = (hex[3:0] == 4'd0) ? hcbd_pkg::PFX_ZERO : hcbd_pkg::PFX_DONE;
				end else begin
					if (data_byte == hcbd_pkg::CHAR_PLUS || data_byte == hcbd_pkg::CHAR_MINUS) begin
						flags_p.bad = 1'b1;
					end
					flags_p.ended = 1'b1;
				end
			end else if (prefix_e == hcbd_pkg::PFX_ZERO
				&& (data_byte == hcbd_pkg::CHAR_X_LC || data_byte == hcbd_pkg::CHAR_X_UC)) begin
				prefix_p = hcbd_pkg::PFX_DONE;
			end else begin
				prefix_p = hcbd_pkg::PFX_DONE;
				if (hex[4]) begin
					take = 1'b1;
				end else begin
					flags_p.ended = 1'b1;
				end
			end
		end
		if (take) begin
			flags_p.digits = 1'b1;
			if (!flags_e.over) begin
				if (acc_e[SIZE_BITS-1 -: 4] != 4'd0) begin
					flags_p.over = 1'b1;
				end else begin
					acc_p = {acc_e[SIZE_BITS-5:0], hex[3:0]};
				end
			end
		end
	end

	// Result of the current byte.
	always_comb begin
		res.kind = hcbd_pkg::KIND_FRAME;
		res.pay  = 8'd0;
		res.err  = hcbd_pkg::ERR_NONE;
		case (phase_e)
			hcbd_pkg::PH_SIZE: begin
				if (is_lf) begin
					if (flags_e.bad || !flags_e.digits) begin
						res.err = hcbd_pkg::ERR_MALFORMED;
					end else if (flags_e.over) begin
						res.err = hcbd_pkg::ERR_OVERFLOW;
					end
				end else if (line_full) begin
					res.err = hcbd_pkg::ERR_LONG;
				end
			end
			hcbd_pkg::PH_DATA: begin
				res.kind = hcbd_pkg::KIND_PAYLOAD;
				res.pay  = data_byte;
			end
			hcbd_pkg::PH_TRAILER: begin
				if (is_lf) begin
					if (line_e == 8'd0 || (line_e == 8'd1 && crf_e)) begin
						res.kind = hcbd_pkg::KIND_DONE;
					end
				end else if (line_full) begin
					res.err = hcbd_pkg::ERR_LONG;
				end
			end
			default: begin
				res.kind = hcbd_pkg::KIND_FRAME;
			end
		endcase
		if (res.err != hcbd_pkg::ERR_NONE) begin
			res.kind = hcbd_pkg::KIND_ERROR;
		end
	end

	// Next parser state.
	always_comb begin
		phase_d  = phase_e;
		rem_d    = rem_e;
		acc_d    = acc_e;
		line_d   = line_e;
		flags_d  = flags_e;
		prefix_d = prefix_e;
		term_d   = term_e;
		crf_d    = crf_e;
		case (phase_e)
			hcbd_pkg::PH_SIZE: begin
				if (is_lf) begin
					if (!flags_e.bad && flags_e.digits && !flags_e.over) begin
						if (acc_e == '0) begin
							phase_d = hcbd_pkg::PH_TRAILER;
						end else begin
							rem_d   = acc_e;
							phase_d = hcbd_pkg::PH_DATA;
						end
						acc_d    = '0;
						line_d   = '0;
						flags_d  = '0;
						prefix_d = hcbd_pkg::PFX_NONE;
						crf_d    = 1'b0;
					end
				end else if (!line_full) begin
					line_d   = line_e + 8'd1;
					flags_d  = flags_p;
					acc_d    = acc_p;
					prefix_d = prefix_p;
				end
			end
			hcbd_pkg::PH_DATA: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = hcbd_pkg::PH_TERM;
					term_d  = 1'b0;
				end
			end
			hcbd_pkg::PH_TERM: begin
				// The two bytes after a chunk's payload are dropped unseen.
				if (term_e) begin
					term_d   = 1'b0;
					phase_d  = hcbd_pkg::PH_SIZE;
					acc_d    = '0;
					line_d   = '0;
					flags_d  = '0;
					prefix_d = hcbd_pkg::PFX_NONE;
					crf_d    = 1'b0;
				end else begin
					term_d = 1'b1;
				end
			end
			hcbd_pkg::PH_TRAILER: begin
				if (is_lf) begin
					if (line_e == 8'd0 || (line_e == 8'd1 && crf_e)) begin
						phase_d = hcbd_pkg::PH_DONE;
					end
					acc_d    = '0;
					line_d   = '0;
					flags_d  = '0;
					prefix_d = hcbd_pkg::PFX_NONE;
					crf_d    = 1'b0;
				end else if (!line_full) begin
					if (line_e == 8'd0 && data_byte == hcbd_pkg::CHAR_CR) begin
						crf_d = 1'b1;
					end
					line_d = line_e + 8'd1;
				end
			end
			default: begin
				phase_d = phase_e;
			end
		endcase
		if (res.err != hcbd_pkg::ERR_NONE) begin
			phase_d = hcbd_pkg::PH_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hcbd_pkg::PH_SIZE;
			rem_q    <= '0;
			acc_q    <= '0;
			line_q   <= '0;
			flags_q  <= '0;
			prefix_q <= hcbd_pkg::PFX_NONE;
			term_q   <= 1'b0;
			crf_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			rem_q    <= rem_d;
			acc_q    <= acc_d;
			line_q   <= line_d;
			flags_q  <= flags_d;
			prefix_q <= prefix_d;
			term_q   <= term_d;
			crf_q    <= crf_d;
		end
	end

	// Output register with a one-word skid register behind it.
	hcbd_pkg::result_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              out_free;

	assign in_ready = !skid_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign payload_byte = out_q.pay;
	assign error_code   = out_q.err;

endmodule

### design/hcbd_checker.sv
`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] payload_byte,
	input logic [1:0] error_code
);

	// A stalled result word must hold still.
	`HCBD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(payload_byte) && $stable(error_code))

	// With nothing waiting at the output the skid register is empty, so input is taken.
	`HCBD_ASSERT_IMP(a_idle_ready, clk, arst_n, !out_valid, in_ready)

	// After every accepted word, out_valid is high on the following cycle.
	`HCBD_ASSERT_NXT(a_accept_valid, clk, arst_n, in_valid && in_ready, out_valid)

	// An error code only travels with an error result.
	`HCBD_ASSERT_IMP(a_err_kind, clk, arst_n, out_valid && (kind != hcbd_pkg::KIND_ERROR), error_code == hcbd_pkg::ERR_NONE)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

	// A run of about 1100 words, each after the longest sender gap and the longest receiver
	// stall, stays below a third of this.
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] LIMIT_ADDR = 3'(4 * int'(hcbd_pkg::REG_MAX_LINE_LEN));
	// Largest accumulator value that may still take one more hex digit.
	localparam logic [hcbd_pkg::SIZE_BITS_DEF-1:0] ACC_SHIFT_MAX =
		{4'h0, {(hcbd_pkg::SIZE_BITS_DEF - 4){1'b1}}};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        new_body = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [1:0]  error_code;

	http_chunked_body_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.new_body(new_body),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.error_code(error_code)
	);

	// Free-running 8 ns clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Decoder state as the bench expects it to be after every accepted word.
	hcbd_pkg::phase_t                   dec_phase;
	logic [hcbd_pkg::SIZE_BITS_DEF-1:0] chunk_left;
	logic [hcbd_pkg::SIZE_BITS_DEF-1:0] size_acc;
	logic [7:0]                         line_len;
	hcbd_pkg::flags_t                   line_flags;
	logic                               cr_first;
	logic [1:0]                         crlf_count;
	hcbd_pkg::prefix_t                  prefix_pos;
	logic [7:0]                         line_limit_reg;

	hcbd_pkg::result_t decoded_q[$];   // expected results, oldest first
	logic [7:0]        body_bytes[$];  // stream under construction
	int                words_sent = 0;
	int                results_seen = 0;
	int                mismatches = 0;
	int                cycle_count = 0;
	bit                steady = 1'b0;  // when set, neither side idles

	task automatic report_mismatch(input string what, input int got, input int wanted);
		$display("mismatch at result %0d: %s is %0d, should be %0d",
			results_seen, what, got, wanted);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Prediction of the decoder.
	// ------------------------------------------------------------------

	function automatic int hex_digit(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39)
			return int'(b) - 'h30;
		if (b >= 8'h61 && b <= 8'h66)
			return int'(b) - 'h57;
		if (b >= 8'h41 && b <= 8'h46)
			return int'(b) - 'h37;
		return -1;
	endfunction

	function automatic bit is_blank(input logic [7:0] b);
		return b == hcbd_pkg::CHAR_SPACE || b == hcbd_pkg::CHAR_TAB ||
			b == hcbd_pkg::CHAR_CR || b == hcbd_pkg::CHAR_VT || b == hcbd_pkg::CHAR_FF;
	endfunction

	function automatic void clear_line();
		size_acc = '0;
		line_len = '0;
		line_flags = '0;
		cr_first = 1'b0;
		prefix_pos = hcbd_pkg::PFX_NONE;
	endfunction

	function automatic void restart_decode();
		dec_phase = hcbd_pkg::PH_SIZE;
		chunk_left = '0;
		crlf_count = '0;
		clear_line();
	endfunction

	// The register can never lift the limit beyond what the line buffer holds.
	function automatic int line_cap();
		int lim;
		lim = line_limit_reg;
		if (lim > hcbd_pkg::LINE_BUFFER_BYTES_DEF - 1)
			lim = hcbd_pkg::LINE_BUFFER_BYTES_DEF - 1;
		return lim;
	endfunction

	// Once a digit would push the value past the counter width, further digits are
	// counted but ignored, and the line is marked as overflowing.
	function automatic void take_hex(input int d);
		line_flags.digits = 1'b1;
		if (line_flags.over)
			return;
		if (size_acc > ACC_SHIFT_MAX) begin
			line_flags.over = 1'b1;
			return;
		end
		size_acc = {size_acc[hcbd_pkg::SIZE_BITS_DEF-5:0], 4'(d)};
	endfunction

	function automatic void scan_size_char(input logic [7:0] b);
		int d;
		if (line_flags.ended)
			return;
		d = hex_digit(b);
		if (!line_flags.digits) begin
			if (is_blank(b))
				return;
			if (d >= 0) begin
				take_hex(d);
				prefix_pos = (d == 0) ? hcbd_pkg::PFX_ZERO : hcbd_pkg::PFX_DONE;
				return;
			end
			// A sign ahead of the first digit spoils the line; anything else just
			// ends the scan, leaving the line without digits.
			if (b == hcbd_pkg::CHAR_PLUS || b == hcbd_pkg::CHAR_MINUS)
				line_flags.bad = 1'b1;
			line_flags.ended = 1'b1;
			return;
		end
		if (prefix_pos == hcbd_pkg::PFX_ZERO &&
			(b == hcbd_pkg::CHAR_X_LC || b == hcbd_pkg::CHAR_X_UC)) begin
			prefix_pos = hcbd_pkg::PFX_DONE;
			return;
		end
		prefix_pos = hcbd_pkg::PFX_DONE;
		if (d >= 0)
			take_hex(d);
		else
			line_flags.ended = 1'b1;
	endfunction

	task automatic predict_word(input logic [7:0] b, input logic restart,
		output hcbd_pkg::result_t r);
		hcbd_pkg::kind_t k;
		logic [7:0]      pay;
		hcbd_pkg::err_t  e;
		k = hcbd_pkg::KIND_FRAME;
		pay = '0;
		e = hcbd_pkg::ERR_NONE;
		if (restart)
			restart_decode();
		case (dec_phase)
			hcbd_pkg::PH_SIZE: begin
				if (b == hcbd_pkg::CHAR_LF) begin
					if (line_flags.bad || !line_flags.digits) begin
						e = hcbd_pkg::ERR_MALFORMED;
					end else if (line_flags.over) begin
						e = hcbd_pkg::ERR_OVERFLOW;
					end else if (size_acc == '0) begin
						dec_phase = hcbd_pkg::PH_TRAILER;
						clear_line();
					end else begin
						chunk_left = size_acc;
						dec_phase = hcbd_pkg::PH_DATA;
						clear_line();
					end
				end else if (int'(line_len) >= line_cap()) begin
					e = hcbd_pkg::ERR_LONG;
				end else begin
					line_len++;
					scan_size_char(b);
				end
			end
			hcbd_pkg::PH_DATA: begin
				k = hcbd_pkg::KIND_PAYLOAD;
				pay = b;
				if (chunk_left != '0)
					chunk_left--;
				if (chunk_left == '0) begin
					dec_phase = hcbd_pkg::PH_TERM;
					crlf_count = '0;
				end
			end
			hcbd_pkg::PH_TERM: begin
				// The two words after a chunk are dropped whatever they hold.
				crlf_count = crlf_count + 2'd1;
				if (crlf_count >= 2'd2) begin
					crlf_count = '0;
					dec_phase = hcbd_pkg::PH_SIZE;
					clear_line();
				end
			end
			hcbd_pkg::PH_TRAILER: begin
				if (b == hcbd_pkg::CHAR_LF) begin
					if (line_len == 0 || (line_len == 1 && cr_first)) begin
						k = hcbd_pkg::KIND_DONE;
						dec_phase = hcbd_pkg::PH_DONE;
					end
					clear_line();
				end else if (int'(line_len) >= line_cap()) begin
					e = hcbd_pkg::ERR_LONG;
				end else begin
					if (line_len == 0 && b == hcbd_pkg::CHAR_CR)
						cr_first = 1'b1;
					line_len++;
				end
			end
			default: begin
			end
		endcase
		if (e != hcbd_pkg::ERR_NONE) begin
			k = hcbd_pkg::KIND_ERROR;
			dec_phase = hcbd_pkg::PH_ERROR;
		end
		r.kind = k;
		r.pay = pay;
		r.err = e;
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure and the result checker.
	// ------------------------------------------------------------------

	always @(posedge clk) begin : ready_gen
		int n;
		int stall_left;
		if (steady) begin
			out_ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			n = $urandom_range(0, 99);
			if (n < 65) begin
				out_ready <= 1'b1;
			end else begin
				// Mostly short stalls, now and then a long one.
				out_ready <= 1'b0;
				stall_left = (n < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
			end
		end
	end

	always @(posedge clk) begin : result_check
		hcbd_pkg::result_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("kind of a result nobody asked for", kind, -1);
			end else begin
				want = decoded_q.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", kind, want.kind);
				if (payload_byte !== want.pay)
					report_mismatch("payload_byte", payload_byte, want.pay);
				if (error_code !== want.err)
					report_mismatch("error_code", error_code, want.err);
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Input side.
	// ------------------------------------------------------------------

	// Offers one word, waits for it to be taken and records what it should produce.
	// Valid is only lowered when an idle gap follows, so back-to-back words keep it high.
	task automatic send_word(input logic [7:0] b, input logic restart);
		int                gap;
		int                n;
		hcbd_pkg::result_t r;
		gap = 0;
		if (!steady) begin
			n = $urandom_range(0, 99);
			if (n >= 92)
				gap = $urandom_range(8, 40);
			else if (n >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		new_body <= restart;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_word(b, restart, r);
		decoded_q.insert(decoded_q.size(), r);
		words_sent++;
	endtask

	// Sends the assembled stream; the first word may restart decoding.
	task automatic send_body(input bit restart);
		foreach (body_bytes[i])
			send_word(body_bytes[i], restart && i == 0);
		body_bytes.delete();
	endtask

	task automatic put_byte(input logic [7:0] b);
		body_bytes.insert(body_bytes.size(), b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_eol();
		put_byte(hcbd_pkg::CHAR_CR);
		put_byte(hcbd_pkg::CHAR_LF);
	endtask

	// Holds the sender back until every word sent so far has produced its result.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_line_limit();
		in_valid <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LIMIT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== line_limit_reg)
			report_mismatch("max_line_len read back", prdata[7:0], line_limit_reg);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// The register is only touched once the decoder has nothing left in flight.
	task automatic set_line_limit(input logic [7:0] value);
		wait_for_results();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		line_limit_reg = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_line_limit();
	endtask

	// A size line for the given size, dressed at random with leading blanks, a 0x prefix,
	// leading zeros, upper-case digits or an extension, and ended by CR LF or a bare LF.
	task automatic put_size_line(input int unsigned size);
		string      digits;
		logic [7:0] blank;
		digits = $sformatf("%0h", size);
		if ($urandom_range(0, 1))
			digits = digits.toupper();
		case ($urandom_range(0, 9))
			0: begin
				repeat ($urandom_range(1, 2)) begin
					case ($urandom_range(0, 4))
						0: blank = hcbd_pkg::CHAR_SPACE;
						1: blank = hcbd_pkg::CHAR_TAB;
						2: blank = hcbd_pkg::CHAR_VT;
						3: blank = hcbd_pkg::CHAR_FF;
						default: blank = hcbd_pkg::CHAR_CR;
					endcase
					put_byte(blank);
				end
			end
			1: digits = {"0x", digits};
			2: digits = {"0X", digits};
			3: digits = {"00", digits};
			default: begin
			end
		endcase
		put_text(digits);
		if ($urandom_range(0, 5) == 0) begin
			if ($urandom_range(0, 1))
				put_text(";ext=v");
			else
				put_text(";q");
		end
		if ($urandom_range(0, 7) != 0)
			put_byte(hcbd_pkg::CHAR_CR);
		put_byte(hcbd_pkg::CHAR_LF);
	endtask

	// One chunked body: a few chunks with random payload, then either a clean ending with
	// optional trailer lines or a spoilt size line.
	task automatic build_body();
		int unsigned size;
		int          flaw;
		string       hexset;
		hexset = "0123456789abcdefABCDEF";
		flaw = $urandom_range(0, 11);
		repeat ($urandom_range(0, 3)) begin
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			put_size_line(size);
			repeat (size) put_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 15) == 0) begin
				put_byte(8'($urandom_range(0, 255)));
				put_byte(8'($urandom_range(0, 255)));
			end else begin
				put_eol();
			end
		end
		case (flaw)
			0: begin
				if ($urandom_range(0, 1))
					put_byte(hcbd_pkg::CHAR_SPACE);
				if ($urandom_range(0, 1))
					put_text("+3");
				else
					put_text("-a");
				put_eol();
			end
			1: begin
				case ($urandom_range(0, 2))
					0: put_text(";x");
					1: put_text("g1");
					default: begin
					end
				endcase
				put_eol();
			end
			2: begin
				put_text("1");
				repeat ($urandom_range(8, 10))
					put_byte(hexset[$urandom_range(0, hexset.len() - 1)]);
				put_byte(hcbd_pkg::CHAR_LF);
			end
			default: begin
				put_size_line(0);
				repeat ($urandom_range(0, 2)) begin
					repeat ($urandom_range(1, 5))
						put_byte(8'($urandom_range(8'h21, 8'h7E)));
					put_eol();
				end
				if ($urandom_range(0, 3) != 0)
					put_byte(hcbd_pkg::CHAR_CR);
				put_byte(hcbd_pkg::CHAR_LF);
			end
		endcase
		// Words after the end or an error should all come back as framing.
		repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
	endtask

	// Loose words biased towards the characters the parser cares about, with the odd
	// restart falling wherever it happens to land.
	task automatic send_noise(input int count);
		string      charset;
		logic [7:0] b;
		int         n;
		charset = "0123456789abcdefxX+-; ";
		repeat (count) begin
			n = $urandom_range(0, 9);
			if (n < 5)
				b = charset[$urandom_range(0, charset.len() - 1)];
			else if (n == 5)
				b = hcbd_pkg::CHAR_CR;
			else if (n == 6)
				b = hcbd_pkg::CHAR_LF;
			else
				b = 8'($urandom_range(0, 255));
			send_word(b, $urandom_range(0, 15) == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// A short well-formed body: prefixed size with an extension and no CR, payload at
	// both extremes, and a trailer section ended by a line holding only CR.
	task automatic test_framing();
		put_text("0X2;");
		put_byte(hcbd_pkg::CHAR_LF);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_eol();
		put_text("0");
		put_byte(hcbd_pkg::CHAR_LF);
		put_eol();
		put_byte(8'hFF);
		send_body(1'b1);
	endtask

	task automatic test_special_cases();
		// A sign after a leading blank spoils the size line.
		put_text(" -1");
		put_byte(hcbd_pkg::CHAR_LF);
		send_body(1'b1);
		// An empty size line has no digits; the word after the error is plain framing.
		put_byte(hcbd_pkg::CHAR_LF);
		put_byte(8'h41);
		send_body(1'b1);
		// Nine digits overflow the size counter.
		put_text("1ffffffff");
		put_byte(hcbd_pkg::CHAR_LF);
		send_body(1'b1);
		// The largest size that fits; decoding is abandoned by the next restart.
		put_text("ffffffff");
		put_byte(hcbd_pkg::CHAR_LF);
		put_byte(8'h5A);
		put_byte(8'hA5);
		send_body(1'b1);
	endtask

	task automatic test_line_limit();
		check_line_limit();
		set_line_limit(8'd1);
		// A one-byte size line is just allowed; the next one has a byte too many.
		put_text("1");
		put_byte(hcbd_pkg::CHAR_LF);
		put_byte(8'h41);
		put_eol();
		put_text("12");
		send_body(1'b1);
		// A trailer line is held to the same limit.
		put_text("0");
		put_byte(hcbd_pkg::CHAR_LF);
		put_text("ab");
		send_body(1'b1);
		set_line_limit(8'd255);
	endtask

	// Random traffic across several line limits, 1 and 255 among them. Each setting
	// is written with the decoder drained, and once per setting the sender also stops
	// mid-way until every result is back.
	task automatic test_random_traffic();
		int unsigned limits[6];
		int          counts[6];
		int          stop;
		bit          paused;
		limits = '{255, 1, 200, 2, 255, 0};
		counts = '{250, 60, 250, 60, 250, 100};
		for (int p = 0; p < 6; p++) begin
			set_line_limit(8'((p == 5) ? $urandom_range(3, 254) : limits[p]));
			stop = words_sent + counts[p];
			paused = 1'b0;
			while (words_sent < stop) begin
				if (!paused && words_sent > stop - counts[p] / 2) begin
					wait_for_results();
					paused = 1'b1;
				end
				steady = ($urandom_range(0, 5) == 0);
				if ($urandom_range(0, 4) == 0) begin
					send_noise($urandom_range(1, 12));
				end else begin
					build_body();
					send_body(1'b1);
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		line_limit_reg = hcbd_pkg::MAX_LINE_LEN_RST;
		restart_decode();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_framing();
		test_special_cases();
		test_line_limit();
		test_random_traffic();
		wait_for_results();
		// Results are registered, so the wait below is ample to catch a stray result.
		repeat (8) @(posedge clk);
		if (decoded_q.size() != 0)
			report_mismatch("results still outstanding", 0, decoded_q.size());
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/hcbd_pkg.sv
design/http_chunked_body_decoder.sv
design/hcbd_checker.sv
bench/tb.sv
